// ----- sv/sml_pkg.sv -----
package sml_pkg;

  localparam int VALUE_W = 32;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic go;
    logic ovf;
  } merge_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } merge_stat_t;

endpackage

// ----- sv/sml_store.sv -----
module sml_store
  import sml_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  value_t        wdata,
  input  logic [AW-1:0] raddr,
  output value_t        rdata
);

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/sml_merge.sv -----
module sml_merge
  import sml_pkg::*;
#(
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  merge_ctrl_t   ctl,
  output merge_stat_t   stat,
  input  logic [CW-1:0] first_count,
  input  logic [CW-1:0] second_count,
  output logic [AW-1:0] a_addr,
  output logic [AW-1:0] b_addr,
  input  value_t        a_data,
  input  value_t        b_data,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,  // merged_value
  output logic          m_tlast,  // final_res
  output logic          m_tuser   // overflow
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] i, i_next, j, j_next;
  logic [CW:0]   total, n, n_inc;
  logic          a_ok, b_ok, take_a, load;
  value_t        pick;

  assign a_addr = i[AW-1:0];
  assign b_addr = j[AW-1:0];

  assign total = {1'b0, first_count} + {1'b0, second_count};
  assign n     = {1'b0, i} + {1'b0, j};
  assign n_inc = n + {{CW{1'b0}}, 1'b1};

  // shared compare unit, one decision per emit cycle in which the output register is free
  assign a_ok   = i < first_count;
  assign b_ok   = j < second_count;
  assign take_a = a_ok && (!b_ok || ($signed(a_data) < $signed(b_data)));
  assign pick   = take_a ? a_data : b_data;

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (ctl.go) begin
          i_next     = '0;
          j_next     = '0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (n == total) begin
          state_next = S_DONE;
        end else if (!m_tvalid || m_tready) begin
          load = 1'b1;
          if (take_a) begin
            i_next = i + CW'(1);
          end else begin
            j_next = j + CW'(1);
          end
          state_next = S_FETCH;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      i        <= '0;
      j        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= pick;
      m_tlast <= (n_inc == total);
      m_tuser <= ctl.ovf;
    end
  end

endmodule

// ----- sv/sorted_list_merge.sv -----
// Two-way merge of two ascending lists of signed 32-bit values. Each input
// transaction appends an element (tuser[1] set) to the list chosen by tuser[0]
// and/or closes that list (tlast); transactions to an already closed list are
// ignored, and values offered to a full list (LIST_DEPTH entries) are dropped
// and reported in tuser of every result of the following merge. Once both
// lists are closed, s_tready drops and the merge runs: one shared compare
// unit decides each result from a registered memory read, then the compare,
// and holds the next decision while a result waits on a stalled output.
// Equal values give the second list's element first. tlast marks the last
// result; a merge of two empty lists produces no result.
module sorted_list_merge
  import sml_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // which_list, carries_value
  input  logic        s_tlast,   // list_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // merged_value
  output logic [0:0]  m_tuser,   // overflow
  output logic        m_tlast    // final_res
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CW-1:0] first_count, second_count;
  logic          first_closed, second_closed, dropped_flag;
  logic          accept, sel, has_val, ends;
  logic          first_take, second_take, first_full, second_full;
  logic          first_we, second_we;
  logic [AW-1:0] a_addr, b_addr;
  value_t        a_data, b_data;
  merge_ctrl_t   ctl;
  merge_stat_t   stat;

  assign s_tready = !(first_closed && second_closed) && !stat.busy;
  assign accept   = s_tvalid && s_tready;
  assign sel      = s_tuser[0];
  assign has_val  = s_tuser[1];
  assign ends     = s_tlast;

  assign first_take  = accept && !sel && !first_closed;
  assign second_take = accept && sel && !second_closed;
  assign first_full  = (first_count >= CW'(LIST_DEPTH));
  assign second_full = (second_count >= CW'(LIST_DEPTH));
  assign first_we    = first_take && has_val && !first_full;
  assign second_we   = second_take && has_val && !second_full;

  assign ctl.go  = first_closed && second_closed;
  assign ctl.ovf = dropped_flag;

  always_ff @(posedge clk) begin
    if (rst || stat.done) begin
      first_count   <= '0;
      second_count  <= '0;
      first_closed  <= 1'b0;
      second_closed <= 1'b0;
      dropped_flag  <= 1'b0;
    end else begin
      if (first_we) begin
        first_count <= first_count + CW'(1);
      end
      if (second_we) begin
        second_count <= second_count + CW'(1);
      end
      if ((first_take && has_val && first_full) ||
          (second_take && has_val && second_full)) begin
        dropped_flag <= 1'b1;
      end
      if (first_take && ends) begin
        first_closed <= 1'b1;
      end
      if (second_take && ends) begin
        second_closed <= 1'b1;
      end
    end
  end

  sml_store #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_first (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (a_addr),
    .rdata (a_data)
  );

  sml_store #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_second (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (b_addr),
    .rdata (b_data)
  );

  sml_merge #(
    .CW (CW),
    .AW (AW)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .first_count  (first_count),
    .second_count (second_count),
    .a_addr       (a_addr),
    .b_addr       (b_addr),
    .a_data       (a_data),
    .b_data       (b_data),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser[0])
  );

endmodule

// ----- sv/sml_checker.sv -----
module sml_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // no loading while a merge still has results to give
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready during merge");

  // result fields known while valid
  a_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
    else $error("unknown result fields");

endmodule

bind sorted_list_merge sml_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sml_pkg::*;

  localparam int DEPTH = 32;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 200;
  localparam int RAND_LOADS = 168;

  typedef struct packed {
    logic   which;
    logic   has_val;
    value_t val;
    logic   ends;
  } load_t;

  typedef struct packed {
    value_t val;
    logic   last;
    logic   ovf;
  } result_t;

  typedef struct {
    bit     which;
    bit     has_val;
    value_t val;
    bit     ends;
    bit     typed;
    int     n_exp;
    value_t e_val;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // value
  logic [1:0]  s_tuser;   // which_list, carries_value
  logic        s_tlast;   // list_end
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // merged_value
  logic [0:0]  m_tuser;   // overflow
  logic        m_tlast;   // final_res

  // predictor state
  value_t  list_a[$];
  value_t  list_b[$];
  bit      a_shut;
  bit      b_shut;
  bit      dropped;
  result_t merge_buf[$];
  result_t merged_due[$];
  result_t want;

  int src_idle;
  int sink_idle;
  int mismatches;
  int cycle_cnt;
  int n_loads;
  int n_ignored;
  int n_merges;
  int n_empty;
  int n_ovf;
  int n_checked;

  plan_row_t plan[24];

  sorted_list_merge #(
    .LIST_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // applies one load and fills merge_buf when the last open list closes
  function automatic bit take_load(load_t it);
    int      i;
    int      j;
    int      total;
    bit      ovf;
    result_t r;
    merge_buf.delete();
    if (it.which ? b_shut : a_shut) return 0;
    if (!it.has_val && !it.ends) return 0;
    if (it.has_val) begin
      if (!it.which && list_a.size() < DEPTH) list_a.push_back(it.val);
      else if (it.which && list_b.size() < DEPTH) list_b.push_back(it.val);
      else dropped = 1;
    end
    if (it.ends) begin
      if (it.which) b_shut = 1;
      else a_shut = 1;
    end
    if (a_shut && b_shut) begin
      i = 0;
      j = 0;
      total = list_a.size() + list_b.size();
      ovf = dropped;
      while (i + j < total) begin
        if (i < list_a.size() &&
            (j >= list_b.size() || $signed(list_a[i]) < $signed(list_b[j]))) begin
          r.val = list_a[i];
          i++;
        end else begin
          r.val = list_b[j];
          j++;
        end
        r.last = (i + j == total);
        r.ovf = ovf;
        merge_buf.push_back(r);
      end
      n_merges++;
      if (total == 0) n_empty++;
      if (ovf) n_ovf++;
      list_a.delete();
      list_b.delete();
      a_shut = 0;
      b_shut = 0;
      dropped = 0;
    end
    return 1;
  endfunction

  // entered after a rising edge, returns right after the transaction is taken
  task automatic send_load(input load_t it, input bit use_pred);
    bit took;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = it.val;
    s_tuser = {it.has_val, it.which};
    s_tlast = it.ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    took = take_load(it);
    if (took) n_loads++;
    else n_ignored++;
    if (use_pred) begin
      foreach (merge_buf[k]) merged_due.push_back(merge_buf[k]);
    end
  endtask

  function automatic value_t next_val(value_t prev, int mode);
    longint v;
    if (mode == 9) return $urandom;
    if (mode < 5) v = longint'($signed(prev)) + $urandom_range(0, 3);
    else v = longint'($signed(prev)) + $urandom_range(0, 32'h00ff_ffff);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return v[31:0];
  endfunction

  // one pair of lists, interleaved, with some noise transactions
  task automatic run_set();
    int     n[2];
    int     sent[2];
    bit     shut[2];
    bit     sep_end[2];
    value_t cur[2];
    int     mode;
    int     k;
    load_t  it;
    mode = $urandom_range(0, 9);
    for (k = 0; k < 2; k++) begin
      n[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 4)
                                        : $urandom_range(0, 8);
      sent[k] = 0;
      shut[k] = 0;
      sep_end[k] = 1'($urandom_range(0, 1));
      if (mode == 0 || mode == 5) cur[k] = 32'h8000_0000 + $urandom_range(0, 3);
      else if (mode == 1 || mode == 6) cur[k] = 32'h7fff_ff00 + $urandom_range(0, 255);
      else cur[k] = $urandom;
    end
    while (!(shut[0] && shut[1])) begin
      k = shut[0] ? 1 : shut[1] ? 0 : $urandom_range(0, 1);
      it.which = k[0];
      it.val = $urandom;
      it.has_val = 1'b0;
      it.ends = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        if (shut[0] || shut[1]) begin
          it.which = shut[0] ? 1'b0 : 1'b1;
          it.has_val = 1'($urandom_range(0, 1));
          it.ends = 1'($urandom_range(0, 1));
        end
        send_load(it, 1'b1);
      end else begin
        if (sent[k] < n[k]) begin
          if (sent[k] != 0) cur[k] = next_val(cur[k], mode);
          it.has_val = 1'b1;
          it.val = cur[k];
          sent[k]++;
          it.ends = (sent[k] == n[k]) && !sep_end[k];
        end else begin
          it.ends = 1'b1;
        end
        if (it.ends) shut[k] = 1;
        send_load(it, 1'b1);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (merged_due.size() == 0) begin
        $display("%0t: unexpected result %h last %b ovf %b",
                 $time, m_tdata, m_tlast, m_tuser[0]);
        mismatches++;
      end else begin
        want = merged_due.pop_front();
        n_checked++;
        if (m_tdata !== want.val || m_tlast !== want.last || m_tuser[0] !== want.ovf) begin
          $display("%0t: expected %h last %b ovf %b, got %h last %b ovf %b", $time,
                   want.val, want.last, want.ovf, m_tdata, m_tlast, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, merged_due.size());
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    load_t   it;
    result_t r;
    int      phase;
    int      target;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    a_shut = 0;
    b_shut = 0;
    dropped = 0;
    mismatches = 0;
    n_loads = 0;
    n_ignored = 0;
    n_merges = 0;
    n_empty = 0;
    n_ovf = 0;
    n_checked = 0;
    src_idle = 36;
    sink_idle = 74;

    // which, has_val, val, ends, typed, n_exp, e_val
    plan[0]  = '{0, 1, 32'h8000_0000, 1, 0, 0, '0};
    plan[1]  = '{1, 0, 32'hffff_ffff, 1, 1, 1, 32'h8000_0000};
    plan[2]  = '{0, 0, 32'h1234_5678, 0, 1, 0, '0};
    plan[3]  = '{1, 0, 32'h0000_0000, 1, 0, 0, '0};
    plan[4]  = '{0, 0, 32'hdead_beef, 1, 1, 0, '0};
    plan[5]  = '{1, 1, 32'h7fff_ffff, 1, 0, 0, '0};
    plan[6]  = '{1, 1, 32'h0000_0005, 1, 0, 0, '0};
    plan[7]  = '{1, 0, 32'h0000_0000, 1, 0, 0, '0};
    plan[8]  = '{0, 1, 32'h7fff_ffff, 1, 0, 0, '0};
    plan[9]  = '{0, 1, 32'hffff_ffff, 0, 0, 0, '0};
    plan[10] = '{1, 1, 32'h0000_0000, 0, 0, 0, '0};
    plan[11] = '{0, 1, 32'h0000_0000, 0, 0, 0, '0};
    plan[12] = '{1, 1, 32'h0000_0001, 0, 0, 0, '0};
    plan[13] = '{0, 1, 32'h7fff_fffe, 1, 0, 0, '0};
    plan[14] = '{1, 1, 32'h7fff_ffff, 1, 0, 0, '0};
    plan[15] = '{1, 1, 32'h8000_0000, 0, 0, 0, '0};
    plan[16] = '{1, 1, 32'h8000_0001, 1, 0, 0, '0};
    plan[17] = '{0, 1, 32'h8000_0000, 0, 0, 0, '0};
    plan[18] = '{0, 0, 32'hffff_ffff, 0, 0, 0, '0};
    plan[19] = '{0, 0, 32'h0000_0000, 1, 0, 0, '0};
    plan[20] = '{0, 1, 32'h5555_5555, 1, 0, 0, '0};
    plan[21] = '{1, 1, 32'haaaa_aaaa, 1, 0, 0, '0};
    plan[22] = '{1, 1, 32'h0000_002a, 1, 0, 0, '0};
    plan[23] = '{0, 0, 32'hffff_ffff, 1, 1, 1, 32'h0000_002a};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    foreach (plan[p]) begin
      it.which = plan[p].which;
      it.has_val = plan[p].has_val;
      it.val = plan[p].val;
      it.ends = plan[p].ends;
      send_load(it, !plan[p].typed);
      if (plan[p].typed && plan[p].n_exp == 1) begin
        r.val = plan[p].e_val;
        r.last = 1'b1;
        r.ovf = 1'b0;
        merged_due.push_back(r);
      end
    end

    target = n_loads;
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      src_idle = (phase == 0) ? 36 : (phase == 1) ? 74 : 0;
      sink_idle = (phase == 0) ? 74 : (phase == 1) ? 36 : 0;
      target += RAND_LOADS / 3;
      while (n_loads < target) run_set();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (merged_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, merged_due.size());
      mismatches++;
    end
    $display("run covered %0d loads and %0d ignored transactions, %0d results checked",
             n_loads, n_ignored, n_checked);
    $display("merges: %0d total, %0d of two empty lists, %0d with overflow",
             n_merges, n_empty, n_ovf);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
